// ===== src/tournament_branch_predictor_assert.svh =====
// Assertion macros for the tournament branch predictor.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define TBP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbp assertion failed");

// Next-cycle implication.
`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbp assertion failed");

`else

`define TBP_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define TBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/tbp_pkg.sv =====
// Package: constants, types and counter update for the tournament branch predictor.
`default_nettype none

package tbp_pkg;

    localparam int PC_FIELD_W          = 10;
    localparam int PC_INDEX_BITS       = 10;
    localparam int LOCAL_HISTORY_BITS  = 10;
    localparam int GLOBAL_HISTORY_BITS = 2;
    localparam int COUNTER_LIMIT       = 2;
    localparam int CHOOSER_LIMIT       = 2;

    localparam int MAX_LIMIT = (COUNTER_LIMIT > CHOOSER_LIMIT) ? COUNTER_LIMIT : CHOOSER_LIMIT;
    localparam int STR_W     = $clog2(MAX_LIMIT + 1);
    localparam int ENTRY_W   = STR_W + 1;

    localparam int GT_AW  = PC_INDEX_BITS + GLOBAL_HISTORY_BITS;
    localparam int LT_AW  = PC_INDEX_BITS + LOCAL_HISTORY_BITS;
    localparam int CLR_W  = (GT_AW > LT_AW) ? GT_AW : LT_AW;

    localparam logic [STR_W-1:0] CTR_LIMIT_VAL = STR_W'(COUNTER_LIMIT);
    localparam logic [STR_W-1:0] CHO_LIMIT_VAL = STR_W'(CHOOSER_LIMIT);

    typedef struct packed {
        logic [STR_W-1:0] strength;
        logic             guess;
    } ctr_entry_t;

    localparam ctr_entry_t INIT_ENTRY = '{strength: CTR_LIMIT_VAL, guess: 1'b0};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LH_RD,
        ST_TBL_RD,
        ST_UPDATE
    } tbp_state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } tbp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } tbp_status_t;

    // Saturating strength counter; at the bottom the guess flips and strength reloads.
    function automatic ctr_entry_t ctr_next(input logic guess, input logic [STR_W-1:0] str,
                                            input logic match, input logic [STR_W-1:0] limit);
        ctr_entry_t r;
        r.guess    = guess;
        r.strength = str;
        if (match) begin
            if (str < limit) begin
                r.strength = str + STR_W'(1);
            end
        end else if (str <= STR_W'(1)) begin
            r.guess    = ~guess;
            r.strength = limit;
        end else begin
            r.strength = str - STR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/tbp_in_if.sv =====
// Branch request channel: resolved branch address bits and outcome.
`default_nettype none

interface tbp_in_if;
    logic                            valid;
    logic                            ready;
    logic [tbp_pkg::PC_FIELD_W-1:0]  pc_index;
    logic                            taken;

    modport source (output valid, output pc_index, output taken, input ready);
    modport sink   (input valid, input pc_index, input taken, output ready);
endinterface

`default_nettype wire

// ===== src/tbp_out_if.sv =====
// Result channel: tournament prediction and component guesses.
`default_nettype none

interface tbp_out_if;
    logic valid;
    logic ready;
    logic prediction;
    logic global_guess;
    logic local_guess;
    logic used_local;
    logic mispredicted;

    modport source (output valid, output prediction, output global_guess,
                    output local_guess, output used_local, output mispredicted,
                    input ready);
    modport sink   (input valid, input prediction, input global_guess,
                    input local_guess, input used_local, input mispredicted,
                    output ready);
endinterface

`default_nettype wire

// ===== src/tournament_branch_predictor.sv =====
// Top level: tournament branch predictor (global, local and chooser).
//
// One resolved branch (pc_index, taken) per request; one result per branch with the
// tournament prediction made before the update, both component guesses, the chosen
// component and the miss flag. A branch passes through the steps accept, local-history
// read, table reads and update; the result register loads at the update step, and no
// new branch is accepted until the previous one has left the update step. The two
// dependent registered memory reads (local history, then the local counter table it
// indexes) set this sequence. The result register lets the next branch be accepted
// while a result waits; a stalled result holds the update step. After reset the block
// runs a clearing pass over the counter and history memories, one entry per cycle for
// all 2^20 = 1,048,576 entries, and accepts no branch until it is done.
`default_nettype none

`include "tournament_branch_predictor_assert.svh"

module tournament_branch_predictor (
    input  wire logic clk,
    input  wire logic rst_n,
    tbp_in_if.sink    branch,
    tbp_out_if.source result
);

    tbp_pkg::tbp_cmd_t    cmd;
    tbp_pkg::tbp_status_t status;

    tbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (branch.valid),
        .in_ready (branch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tbp_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .pc_index (branch.pc_index),
        .taken    (branch.taken),
        .result   (result)
    );

    `TBP_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, cmd.clear, !branch.ready)
    `TBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, branch.valid && branch.ready, !branch.ready)
    `TBP_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.commit, !result.valid || result.ready)
    `TBP_ASSERT_NEXT(a_commit_gives_result, clk, rst_n, cmd.commit, result.valid)

endmodule

`default_nettype wire

// ===== src/tbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/tbp_ctrl.sv =====
// Controller state machine: clearing pass, request accept, read sequencing, commit.
`default_nettype none

module tbp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tbp_pkg::tbp_status_t status,
    output tbp_pkg::tbp_cmd_t         cmd
);

    tbp_pkg::tbp_state_t state_reg;
    tbp_pkg::tbp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbp_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            tbp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tbp_pkg::ST_LH_RD;
                end
            end
            tbp_pkg::ST_LH_RD:  state_next = tbp_pkg::ST_TBL_RD;
            tbp_pkg::ST_TBL_RD: state_next = tbp_pkg::ST_UPDATE;
            tbp_pkg::ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = tbp_pkg::ST_IDLE;
                end
            end
            default:            state_next = tbp_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            tbp_pkg::ST_CLEAR:  cmd.clear = 1'b1;
            tbp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            tbp_pkg::ST_LH_RD:  ;
            tbp_pkg::ST_TBL_RD: ;
            tbp_pkg::ST_UPDATE: cmd.commit = status.out_free;
            default:            ;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tbp_datapath.sv =====
// Datapath: history and counter memories, chooser, update logic, result register.
`default_nettype none

module tbp_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tbp_pkg::tbp_cmd_t               cmd,
    output tbp_pkg::tbp_status_t                 status,
    input  wire logic [tbp_pkg::PC_FIELD_W-1:0]  pc_index,
    input  wire logic                            taken,
    tbp_out_if.source                            result
);

    localparam int PCW = tbp_pkg::PC_INDEX_BITS;
    localparam int LHW = tbp_pkg::LOCAL_HISTORY_BITS;
    localparam int GHW = tbp_pkg::GLOBAL_HISTORY_BITS;
    localparam int EW  = tbp_pkg::ENTRY_W;

    logic [PCW-1:0]             pc_reg;
    logic                       taken_reg;
    logic [GHW-1:0]             ghist_reg;
    logic                       sel_reg;
    logic [tbp_pkg::STR_W-1:0]  cho_str_reg;
    logic [tbp_pkg::CLR_W-1:0]  clr_reg;

    logic                       out_valid_reg;
    logic                       pred_reg;
    logic                       gg_reg;
    logic                       lg_reg;
    logic                       used_reg;
    logic                       miss_reg;

    logic [LHW-1:0]             lh_rdata;
    logic [EW-1:0]              gt_rdata;
    logic [EW-1:0]              lt_rdata;
    logic [tbp_pkg::GT_AW-1:0]  gi;
    logic [tbp_pkg::LT_AW-1:0]  li;

    tbp_pkg::ctr_entry_t        gt_entry;
    tbp_pkg::ctr_entry_t        lt_entry;
    tbp_pkg::ctr_entry_t        gt_new;
    tbp_pkg::ctr_entry_t        lt_new;
    tbp_pkg::ctr_entry_t        cho_new;

    logic                       pred;
    logic                       hit;
    logic                       we;

    logic [PCW-1:0]             lh_waddr;
    logic [LHW-1:0]             lh_wdata;
    logic [tbp_pkg::GT_AW-1:0]  gt_waddr;
    logic [EW-1:0]              gt_wdata;
    logic [tbp_pkg::LT_AW-1:0]  lt_waddr;
    logic [EW-1:0]              lt_wdata;

    assign gi = {pc_reg, ghist_reg};
    assign li = {pc_reg, lh_rdata};

    assign gt_entry = tbp_pkg::ctr_entry_t'(gt_rdata);
    assign lt_entry = tbp_pkg::ctr_entry_t'(lt_rdata);

    assign pred = sel_reg ? lt_entry.guess : gt_entry.guess;
    assign hit  = (pred == taken_reg);

    assign gt_new  = tbp_pkg::ctr_next(gt_entry.guess, gt_entry.strength,
                                       gt_entry.guess == taken_reg, tbp_pkg::CTR_LIMIT_VAL);
    assign lt_new  = tbp_pkg::ctr_next(lt_entry.guess, lt_entry.strength,
                                       lt_entry.guess == taken_reg, tbp_pkg::CTR_LIMIT_VAL);
    assign cho_new = tbp_pkg::ctr_next(sel_reg, cho_str_reg, hit, tbp_pkg::CHO_LIMIT_VAL);

    assign we = cmd.clear | cmd.commit;

    always_comb
    begin
        if (cmd.clear)
        begin
            lh_waddr = clr_reg[PCW-1:0];
            lh_wdata = '0;
            gt_waddr = clr_reg[tbp_pkg::GT_AW-1:0];
            gt_wdata = tbp_pkg::INIT_ENTRY;
            lt_waddr = clr_reg[tbp_pkg::LT_AW-1:0];
            lt_wdata = tbp_pkg::INIT_ENTRY;
        end
        else
        begin
            lh_waddr = pc_reg;
            lh_wdata = LHW'({lh_rdata, taken_reg});
            gt_waddr = gi;
            gt_wdata = gt_new;
            lt_waddr = li;
            lt_wdata = lt_new;
        end
    end

    tbp_ram #(
        .WIDTH (LHW),
        .DEPTH (1 << PCW)
    ) u_lh_ram (
        .clk   (clk),
        .we    (we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .raddr (pc_reg),
        .rdata (lh_rdata)
    );

    tbp_ram #(
        .WIDTH (EW),
        .DEPTH (1 << tbp_pkg::GT_AW)
    ) u_gt_ram (
        .clk   (clk),
        .we    (we),
        .waddr (gt_waddr),
        .wdata (gt_wdata),
        .raddr (gi),
        .rdata (gt_rdata)
    );

    tbp_ram #(
        .WIDTH (EW),
        .DEPTH (1 << tbp_pkg::LT_AW)
    ) u_lt_ram (
        .clk   (clk),
        .we    (we),
        .waddr (lt_waddr),
        .wdata (lt_wdata),
        .raddr (li),
        .rdata (lt_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pc_reg    <= pc_index[PCW-1:0];
            taken_reg <= taken;
        end
        if (cmd.commit)
        begin
            pred_reg <= pred;
            gg_reg   <= gt_entry.guess;
            lg_reg   <= lt_entry.guess;
            used_reg <= sel_reg;
            miss_reg <= ~hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ghist_reg     <= '0;
            sel_reg       <= 1'b0;
            cho_str_reg   <= tbp_pkg::CHO_LIMIT_VAL;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + tbp_pkg::CLR_W'(1);
            end
            if (cmd.commit)
            begin
                ghist_reg     <= GHW'({ghist_reg, taken_reg});
                sel_reg       <= cho_new.guess;
                cho_str_reg   <= cho_new.strength;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clr_last = &clr_reg;
    assign status.out_free = ~out_valid_reg | result.ready;

    assign result.valid        = out_valid_reg;
    assign result.prediction   = pred_reg;
    assign result.global_guess = gg_reg;
    assign result.local_guess  = lg_reg;
    assign result.used_local   = used_reg;
    assign result.mispredicted = miss_reg;

endmodule

`default_nettype wire

// ===== test/tournament_branch_predictor_tb.sv =====
// Testbench for the tournament branch predictor: branch streams against a predictor model.
`default_nettype none

module tournament_branch_predictor_tb;
    import tbp_pkg::*;

    typedef struct {
        logic [PC_FIELD_W-1:0] pc;
        logic                  taken;
    } branch_t;

    typedef struct packed {
        logic prediction;
        logic global_guess;
        logic local_guess;
        logic used_local;
        logic mispredicted;
    } outcome_t;

    logic clk;
    logic rst_n;

    tbp_in_if  branch_if ();
    tbp_out_if result_if ();

    tournament_branch_predictor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch_if),
        .result (result_if)
    );

    branch_t  branch_queue[$];
    outcome_t expected_outcomes[$];

    // predictor state
    logic [GLOBAL_HISTORY_BITS-1:0] glob_hist;
    ctr_entry_t                     glob_tab [0:(1 << GT_AW)-1];
    logic [LOCAL_HISTORY_BITS-1:0]  loc_hist [0:(1 << PC_INDEX_BITS)-1];
    ctr_entry_t                     loc_tab [int unsigned];
    logic                           sel_local;
    logic [STR_W-1:0]               cho_str;

    int errors;
    int accepted;
    int observed;
    int misses;
    int local_uses;
    int drv_gap;
    int drv_mode;
    int mon_gap;
    int mon_mode;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic ctr_entry_t train(input ctr_entry_t e, input logic hit,
                                         input int limit);
        ctr_entry_t n;
        n = e;
        if (hit)
        begin
            if (e.strength < limit)
                n.strength = e.strength + 1'b1;
        end
        else if (e.strength <= 1)
        begin
            n.guess    = ~e.guess;
            n.strength = STR_W'(limit);
        end
        else
        begin
            n.strength = e.strength - 1'b1;
        end
        return n;
    endfunction

    function automatic void predict_branch(input logic [PC_FIELD_W-1:0] pc_in,
                                           input logic t);
        logic [PC_INDEX_BITS-1:0]      pc;
        logic [LOCAL_HISTORY_BITS-1:0] lh;
        logic [GT_AW-1:0]              gi;
        logic [LT_AW-1:0]              li;
        ctr_entry_t                    ge;
        ctr_entry_t                    le;
        ctr_entry_t                    ce;
        outcome_t                      o;
        pc = pc_in[PC_INDEX_BITS-1:0];
        lh = loc_hist[pc];
        gi = {pc, glob_hist};
        li = {pc, lh};
        ge = glob_tab[gi];
        if (loc_tab.exists(li))
            le = loc_tab[li];
        else
            le = '{strength: STR_W'(COUNTER_LIMIT), guess: 1'b0};
        o.global_guess = ge.guess;
        o.local_guess  = le.guess;
        o.used_local   = sel_local;
        o.prediction   = sel_local ? le.guess : ge.guess;
        o.mispredicted = o.prediction != t;
        glob_tab[gi] = train(ge, ge.guess == t, COUNTER_LIMIT);
        loc_tab[li]  = train(le, le.guess == t, COUNTER_LIMIT);
        ce = '{strength: cho_str, guess: sel_local};
        ce = train(ce, !o.mispredicted, CHOOSER_LIMIT);
        sel_local = ce.guess;
        cho_str   = ce.strength;
        glob_hist   = GLOBAL_HISTORY_BITS'({glob_hist, t});
        loc_hist[pc] = LOCAL_HISTORY_BITS'({lh, t});
        expected_outcomes.push_back(o);
    endfunction

    function automatic int draw_gap(input int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic exp_v, input logic got_v);
        errors++;
        if (errors <= 40)
            $display("mismatch at request %0d: %s expected %0b got %0b",
                     observed, what, exp_v, got_v);
    endtask

    task automatic add_branch(input int pc, input logic t);
        branch_t b;
        b.pc    = PC_FIELD_W'(pc);
        b.taken = t;
        branch_queue.push_back(b);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            branch_if.valid <= 1'b0;
        end
        else
        begin
            if (branch_if.valid && branch_if.ready)
            begin
                predict_branch(branch_if.pc_index, branch_if.taken);
                accepted++;
                if (accepted % 150 == 0)
                    drv_mode = $urandom_range(0, 2);
            end
            if (!branch_if.valid || branch_if.ready)
            begin
                if (drv_gap > 0)
                begin
                    branch_if.valid <= 1'b0;
                    drv_gap--;
                end
                else if (branch_queue.size() > 0)
                begin
                    branch_if.valid    <= 1'b1;
                    branch_if.pc_index <= branch_queue[0].pc;
                    branch_if.taken    <= branch_queue[0].taken;
                    void'(branch_queue.pop_front());
                    drv_gap = draw_gap(drv_mode);
                end
                else
                begin
                    branch_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                observed++;
                if (result_if.mispredicted)
                    misses++;
                if (result_if.used_local)
                    local_uses++;
                if (expected_outcomes.size() == 0)
                begin
                    errors++;
                    if (errors <= 40)
                        $display("unexpected result at request %0d", observed);
                end
                else
                begin
                    exp_o = expected_outcomes.pop_front();
                    if (exp_o.prediction !== result_if.prediction)
                        report_mismatch("prediction", exp_o.prediction, result_if.prediction);
                    if (exp_o.global_guess !== result_if.global_guess)
                        report_mismatch("global_guess", exp_o.global_guess,
                                        result_if.global_guess);
                    if (exp_o.local_guess !== result_if.local_guess)
                        report_mismatch("local_guess", exp_o.local_guess,
                                        result_if.local_guess);
                    if (exp_o.used_local !== result_if.used_local)
                        report_mismatch("used_local", exp_o.used_local, result_if.used_local);
                    if (exp_o.mispredicted !== result_if.mispredicted)
                        report_mismatch("mispredicted", exp_o.mispredicted,
                                        result_if.mispredicted);
                end
                if (observed % 170 == 0)
                    mon_mode = $urandom_range(0, 2);
            end
            if (mon_gap > 0)
            begin
                result_if.ready <= 1'b0;
                mon_gap--;
            end
            else
            begin
                result_if.ready <= 1'b1;
                mon_gap = draw_gap(mon_mode);
            end
        end
    end

    initial
    begin
        int npc;
        int rounds;
        int period [4];
        int pcs [4];
        logic [7:0] pattern [4];
        logic t;
        int k;

        rst_n              = 1'b0;
        branch_if.valid    = 1'b0;
        branch_if.pc_index = '0;
        branch_if.taken    = 1'b0;
        result_if.ready    = 1'b0;
        errors     = 0;
        accepted   = 0;
        observed   = 0;
        misses     = 0;
        local_uses = 0;
        drv_gap    = 0;
        drv_mode   = 0;
        mon_gap    = 0;
        mon_mode   = 1;

        glob_hist = '0;
        sel_local = 1'b0;
        cho_str   = STR_W'(CHOOSER_LIMIT);
        foreach (glob_tab[i])
            glob_tab[i] = '{strength: STR_W'(COUNTER_LIMIT), guess: 1'b0};
        foreach (loc_hist[i])
            loc_hist[i] = '0;

        // directed: extremes, counter flips, chooser swapping to local and back
        add_branch(0, 1'b0);
        add_branch(1023, 1'b1);
        add_branch(1023, 1'b1);
        add_branch(1023, 1'b1);
        add_branch(1023, 1'b1);
        add_branch(0, 1'b1);
        add_branch(0, 1'b1);
        add_branch(0, 1'b0);
        add_branch(1023, 1'b0);
        add_branch(1023, 1'b0);
        add_branch(512, 1'b1);
        add_branch(512, 1'b1);
        add_branch(512, 1'b1);
        add_branch(341, 1'b1);
        add_branch(341, 1'b0);
        add_branch(341, 1'b1);
        add_branch(682, 1'b0);
        add_branch(682, 1'b1);
        add_branch(682, 1'b0);
        add_branch(1, 1'b1);
        add_branch(1, 1'b1);
        add_branch(1, 1'b1);
        add_branch(1023, 1'b1);
        add_branch(0, 1'b0);

        // random: mostly periodic branch streams on a few PCs, some noise
        while (branch_queue.size() < 1700)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                k = $urandom_range(1, 12);
                repeat (k)
                    add_branch($urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            end
            else
            begin
                npc    = $urandom_range(1, 4);
                rounds = $urandom_range(10, 50);
                for (int i = 0; i < npc; i++)
                begin
                    pcs[i]     = $urandom_range(0, 1023);
                    period[i]  = $urandom_range(1, 8);
                    pattern[i] = 8'($urandom());
                    if ($urandom_range(0, 3) == 0)
                        pattern[i] = ~(8'd1 << (period[i] - 1));
                end
                for (int r = 0; r < rounds; r++)
                begin
                    for (int i = 0; i < npc; i++)
                    begin
                        t = pattern[i][r % period[i]];
                        if ($urandom_range(0, 99) < 3)
                            t = ~t;
                        add_branch(pcs[i], t);
                    end
                end
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (branch_queue.size() > 0 || branch_if.valid);
        do @(posedge clk);
        while (expected_outcomes.size() > 0);
        repeat (20) @(posedge clk);

        $display("ran %0d branches, %0d results checked", accepted, observed);
        $display("tournament misses %0d, local predictor chosen %0d times", misses, local_uses);
        if (errors == 0 && expected_outcomes.size() == 0)
            $display("tournament_branch_predictor_tb OK");
        else
            $display("tournament_branch_predictor_tb NOT OK");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("timeout: %0d results still outstanding", expected_outcomes.size());
        $display("tournament_branch_predictor_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== tournament_branch_predictor.f =====
+incdir+src
src/tbp_pkg.sv
src/tbp_in_if.sv
src/tbp_out_if.sv
src/tbp_ram.sv
src/tbp_ctrl.sv
src/tbp_datapath.sv
src/tournament_branch_predictor.sv
test/tournament_branch_predictor_tb.sv
